>>> src/bpb_pkg.sv
// Package: shared types and constants for the branch predictor with BTB
`default_nettype none
package bpb_pkg;
    localparam int LINES_LOG2  = 5;
    localparam int MAX_LINES   = 1 << LINES_LOG2;
    localparam int MAX_HISTORY = 8;
    localparam int ROW_SIZE    = 1 << MAX_HISTORY;
    localparam int TAG_BITS    = 30;
    localparam int LMEM_DEPTH  = MAX_LINES * ROW_SIZE;
    localparam int LMEM_AW     = LINES_LOG2 + MAX_HISTORY;

    localparam logic [2:0] CFG_LINES       = 3'd0;
    localparam logic [2:0] CFG_HISTORY     = 3'd1;
    localparam logic [2:0] CFG_TAG         = 3'd2;
    localparam logic [2:0] CFG_INIT        = 3'd3;
    localparam logic [2:0] CFG_GLOBAL_HIST = 3'd4;
    localparam logic [2:0] CFG_GLOBAL_TBL  = 3'd5;
    localparam logic [2:0] CFG_SHARE       = 3'd6;

    localparam logic [1:0] SM_PC2  = 2'd1;
    localparam logic [1:0] SM_PC16 = 2'd2;

    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [1:0] CNT_SNT = 2'd0;
    localparam logic [1:0] CNT_WT  = 2'd2;
    localparam logic [1:0] CNT_ST  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] pc;
        logic [31:0] target_address;
        logic        taken;
        logic [31:0] predicted_address;
    } t_in_item;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] predicted_target;
        logic        flush;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic look;
        logic sweep;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
        logic out_free;
    } t_ctl_sts;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_CALC  = 4'b1000
    } t_state;
endpackage
`default_nettype wire

>>> src/bpb_ctrl.sv
// Controller: sequences lookup, row clear and commit of each transaction
`default_nettype none
module bpb_ctrl import bpb_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_sts.need_sweep ? S_SWEEP : S_CALC;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> src/bpb_datapath.sv
// Datapath: configuration, BTB lines, histories, counter tables and result register
`default_nettype none
module bpb_datapath import bpb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_item   i_in,
    input  wire logic       i_cfg_valid,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out,
    input  wire t_ctl_cmd   i_cmd,
    output t_ctl_sts        o_sts
);
    logic [2:0] r_lg;
    logic [3:0] r_hl;
    logic [4:0] r_tl;
    logic [1:0] r_init;
    logic       r_gh, r_gt;
    logic [1:0] r_sm;
    logic       cfg_clear;

    logic                   r_valid [MAX_LINES];
    logic [TAG_BITS-1:0]    r_tag   [MAX_LINES];
    logic [31:0]            r_tgt   [MAX_LINES];
    logic [MAX_HISTORY-1:0] r_lhist [MAX_LINES];
    logic [MAX_HISTORY-1:0] r_shist;
    logic                   r_sv    [ROW_SIZE];
    logic [1:0]             r_lmem  [LMEM_DEPTH];
    logic [1:0]             r_smem  [ROW_SIZE];

    t_in_item               r_in;
    logic [LINES_LOG2-1:0]  r_line;
    logic [TAG_BITS-1:0]    r_tagq;
    logic                   r_hit, r_use_init, r_sval;
    logic [MAX_HISTORY-1:0] r_hist, r_sidx, r_sc;
    logic [1:0]             r_lrd, r_srd;
    logic [31:0]            r_ltgt;
    logic [31:0]            r_bcnt, r_fcnt;
    logic                   r_ov;
    t_out_item              r_out;
    t_out_item              n_out;

    logic [2:0]             eff_lg;
    logic [3:0]             eff_h;
    logic [4:0]             eff_tb;
    logic [MAX_HISTORY-1:0] hmask, hsrc, hist, sidx, nhist;
    logic [LINES_LOG2-1:0]  lmask, line;
    logic [TAG_BITS-1:0]    tmask, tag;
    logic [29:0]            word;
    logic                   hit, miss_upd;
    logic [1:0]             cnt, cnt_new;
    logic [31:0]            pc4;
    logic                   fl, upd, lm_we;
    logic [LMEM_AW-1:0]     lm_wa;
    logic [1:0]             lm_wd;

    assign cfg_clear = i_cfg_valid && (i_cfg_index <= CFG_SHARE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg   <= '0;
            r_hl   <= 4'd1;
            r_tl   <= '0;
            r_init <= 2'd1;
            r_gh   <= 1'b0;
            r_gt   <= 1'b0;
            r_sm   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINES:       r_lg   <= i_cfg_data[2:0];
                CFG_HISTORY:     r_hl   <= i_cfg_data[3:0];
                CFG_TAG:         r_tl   <= i_cfg_data;
                CFG_INIT:        r_init <= i_cfg_data[1:0];
                CFG_GLOBAL_HIST: r_gh   <= i_cfg_data[0];
                CFG_GLOBAL_TBL:  r_gt   <= i_cfg_data[0];
                CFG_SHARE:       r_sm   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_lg = (r_lg > 3'(LINES_LOG2)) ? 3'(LINES_LOG2) : r_lg;
        eff_h  = (r_hl == 4'd0) ? 4'd1
               : ((r_hl > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : r_hl);
        eff_tb = (r_tl > 5'(TAG_BITS)) ? 5'(TAG_BITS) : r_tl;
        hmask  = ~({MAX_HISTORY{1'b1}} << eff_h);
        lmask  = ~({LINES_LOG2{1'b1}} << eff_lg);
        tmask  = ~({TAG_BITS{1'b1}} << eff_tb);
        word   = r_in.pc[31:2];
        line   = word[LINES_LOG2-1:0] & lmask;
        tag    = (word >> eff_lg) & tmask;
        hit    = r_valid[line] && (r_tag[line] == tag);
        miss_upd = (r_in.kind == KIND_UPDATE) && !(r_gh && r_gt) && !hit;
        hsrc   = r_gh ? r_shist : (miss_upd ? '0 : r_lhist[line]);
        hist   = hsrc & hmask;
        unique case (r_sm)
            SM_PC2:  sidx = (hist ^ word[MAX_HISTORY-1:0]) & hmask;
            SM_PC16: sidx = (hist ^ r_in.pc[16 +: MAX_HISTORY]) & hmask;
            default: sidx = hist;
        endcase
    end

    always_comb begin
        if (r_gt) begin
            cnt = r_sval ? r_srd : r_init;
        end else begin
            cnt = r_use_init ? r_init : r_lrd;
        end
        if (r_in.taken) begin
            cnt_new = (cnt == CNT_ST) ? cnt : cnt + 2'd1;
        end else begin
            cnt_new = (cnt == CNT_SNT) ? cnt : cnt - 2'd1;
        end
        nhist = {r_hist[MAX_HISTORY-2:0], r_in.taken} & hmask;
        pc4   = r_in.pc + 32'd4;
        fl    = r_in.taken ? (r_in.predicted_address != r_in.target_address)
                           : (r_in.predicted_address != pc4);
        upd   = i_cmd.commit && (r_in.kind == KIND_UPDATE);
        lm_we = i_cmd.sweep || (upd && !r_gt);
        lm_wa = i_cmd.sweep ? {r_line, r_sc} : {r_line, r_hist};
        lm_wd = i_cmd.sweep ? r_init : cnt_new;
        n_out = '0;
        if (r_in.kind == KIND_UPDATE) begin
            n_out.flush        = fl;
            n_out.branch_count = r_bcnt + 32'd1;
            n_out.flush_count  = r_fcnt + {31'd0, fl};
        end else if (r_hit && (cnt >= CNT_WT)) begin
            n_out.predict_taken    = 1'b1;
            n_out.predicted_target = r_ltgt;
        end else begin
            n_out.predicted_target = pc4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in;
        end
        if (i_cmd.look) begin
            r_line     <= line;
            r_tagq     <= tag;
            r_hit      <= hit;
            r_use_init <= miss_upd;
            r_hist     <= hist;
            r_sidx     <= sidx;
            r_ltgt     <= r_tgt[line];
            r_lrd      <= r_lmem[{line, hist}];
            r_srd      <= r_smem[sidx];
            r_sval     <= r_sv[sidx];
        end
        if (lm_we) begin
            r_lmem[lm_wa] <= lm_wd;
        end
        if (upd && r_gt) begin
            r_smem[r_sidx] <= cnt_new;
        end
        if (upd) begin
            r_tag[r_line] <= r_tagq;
            r_tgt[r_line] <= r_in.target_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= '0;
        end else if (i_cmd.look) begin
            r_sc <= '0;
        end else if (i_cmd.sweep) begin
            r_sc <= r_sc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear) begin
            for (int i = 0; i < MAX_LINES; i++) begin
                r_valid[i] <= 1'b0;
                r_lhist[i] <= '0;
            end
            for (int i = 0; i < ROW_SIZE; i++) begin
                r_sv[i] <= 1'b0;
            end
            r_shist <= '0;
        end else if (upd) begin
            r_valid[r_line] <= 1'b1;
            if (r_gh) begin
                r_shist <= nhist;
            end else begin
                r_lhist[r_line] <= nhist;
            end
            if (r_gt) begin
                r_sv[r_sidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
            r_fcnt <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (upd) begin
                r_bcnt <= r_bcnt + 32'd1;
                if (fl) begin
                    r_fcnt <= r_fcnt + 32'd1;
                end
            end
            if (i_cmd.commit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out            = r_out;
    assign o_sts.need_sweep = miss_upd && !r_gt;
    assign o_sts.sweep_last = (r_sc == MAX_HISTORY'(ROW_SIZE - 1));
    assign o_sts.out_free   = !r_ov || i_out_ready;
endmodule
`default_nettype wire

>>> src/two_level_branch_predictor_btb.sv
// A result is registered at commit in the calc state, after the look state;
// a new transaction is taken only after the last one commits. An update that
// misses with per-line counter tables first resets that line's counter row.
// Reset: synchronous, active low; clears configuration, valid bits, histories
// and counts at once, with no clearing pass.
`default_nettype none
module two_level_branch_predictor_btb import bpb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data
);
    t_ctl_cmd cmd;
    t_ctl_sts sts;

    assign o_cfg_ready = 1'b1;

    bpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bpb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule
`default_nettype wire

>>> dv/bpb_checker.sv
// Checker: tracks the predictor state, predicts each result and compares it with the output
`timescale 1ns / 100ps
`default_nettype none
module bpb_checker import bpb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire t_in_item   i_in,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_out_item  i_out,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);
    logic [2:0]  lines_log2;
    logic [3:0]  hist_len;
    logic [4:0]  tag_len;
    logic [1:0]  init_cnt;
    logic        glob_hist;
    logic        glob_tbl;
    logic [1:0]  share;

    logic        line_valid  [MAX_LINES];
    logic [29:0] line_tag    [MAX_LINES];
    logic [31:0] line_target [MAX_LINES];
    logic [7:0]  line_hist   [MAX_LINES];
    logic [7:0]  shared_hist;
    logic [1:0]  line_cnt    [MAX_LINES][ROW_SIZE];
    logic [1:0]  shared_cnt  [ROW_SIZE];
    logic [31:0] branches;
    logic [31:0] flushes;

    t_out_item   expected_q[$];

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("MISMATCH %0t: %s expected %h got %h", $time, what, want, got);
        o_fail_count++;
    endtask

    task automatic clear_tables();
        for (int l = 0; l < MAX_LINES; l++) begin
            line_valid[l] = 1'b0;
            line_hist[l]  = '0;
            for (int r = 0; r < ROW_SIZE; r++) line_cnt[l][r] = init_cnt;
        end
        for (int r = 0; r < ROW_SIZE; r++) shared_cnt[r] = init_cnt;
        shared_hist = '0;
    endtask

    function automatic logic [1:0] trained(input logic [1:0] c, input logic t);
        if (t) return (c == CNT_ST) ? c : c + 2'd1;
        return (c == CNT_SNT) ? c : c - 2'd1;
    endfunction

    task automatic predict_branch(input t_in_item it, output t_out_item res);
        int unsigned lg, hl, tl, line, sidx;
        logic [7:0]  hmask, hist;
        logic [29:0] word, tag;
        logic [31:0] pc4;
        logic        hit, fl;
        lg    = (lines_log2 > LINES_LOG2) ? LINES_LOG2 : lines_log2;
        hl    = (hist_len == 0) ? 1 : (hist_len > MAX_HISTORY) ? MAX_HISTORY : hist_len;
        tl    = (tag_len > TAG_BITS) ? TAG_BITS : tag_len;
        hmask = 8'((1 << hl) - 1);
        word  = it.pc[31:2];
        line  = int'(word) & ((1 << lg) - 1);
        tag   = (word >> lg) & 30'((64'd1 << tl) - 1);
        pc4   = it.pc + 32'd4;
        hit   = line_valid[line] && line_tag[line] == tag;
        res   = '0;
        if (it.kind != KIND_UPDATE) begin
            if (hit) begin
                hist = (glob_hist ? shared_hist : line_hist[line]) & hmask;
                case (share)
                    SM_PC2:  sidx = (hist ^ it.pc[9:2]) & hmask;
                    SM_PC16: sidx = (hist ^ it.pc[23:16]) & hmask;
                    default: sidx = hist;
                endcase
                res.predict_taken = (glob_tbl ? shared_cnt[sidx] : line_cnt[line][hist]) >= CNT_WT;
            end
            res.predicted_target = res.predict_taken ? line_target[line] : pc4;
            return;
        end
        if (!(glob_hist && glob_tbl) && !hit) begin
            if (!glob_hist) line_hist[line] = '0;
            if (!glob_tbl) for (int r = 0; r < ROW_SIZE; r++) line_cnt[line][r] = init_cnt;
        end
        hist = (glob_hist ? shared_hist : line_hist[line]) & hmask;
        case (share)
            SM_PC2:  sidx = (hist ^ it.pc[9:2]) & hmask;
            SM_PC16: sidx = (hist ^ it.pc[23:16]) & hmask;
            default: sidx = hist;
        endcase
        if (glob_tbl) shared_cnt[sidx] = trained(shared_cnt[sidx], it.taken);
        else line_cnt[line][hist] = trained(line_cnt[line][hist], it.taken);
        hist = ((hist << 1) | it.taken) & hmask;
        if (glob_hist) shared_hist = hist; else line_hist[line] = hist;
        line_tag[line]    = tag;
        line_valid[line]  = 1'b1;
        line_target[line] = it.target_address;
        branches++;
        fl = it.taken ? (it.predicted_address != it.target_address)
                      : (it.predicted_address != pc4);
        if (fl) flushes++;
        res.flush        = fl;
        res.branch_count = branches;
        res.flush_count  = flushes;
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            lines_log2 = '0;
            hist_len   = 4'd1;
            tag_len    = '0;
            init_cnt   = 2'd1;
            glob_hist  = 1'b0;
            glob_tbl   = 1'b0;
            share      = '0;
            branches   = '0;
            flushes    = '0;
            clear_tables();
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected transaction", 32'd0, 32'd1);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.predict_taken !== want.predict_taken)
                        report("predict_taken", 32'(want.predict_taken),
                               32'(i_out.predict_taken));
                    if (i_out.predicted_target !== want.predicted_target)
                        report("predicted_target", want.predicted_target,
                               i_out.predicted_target);
                    if (i_out.flush !== want.flush)
                        report("flush", 32'(want.flush), 32'(i_out.flush));
                    if (i_out.branch_count !== want.branch_count)
                        report("branch_count", want.branch_count, i_out.branch_count);
                    if (i_out.flush_count !== want.flush_count)
                        report("flush_count", want.flush_count, i_out.flush_count);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINES:       lines_log2 = i_cfg_data[2:0];
                    CFG_HISTORY:     hist_len   = i_cfg_data[3:0];
                    CFG_TAG:         tag_len    = i_cfg_data;
                    CFG_INIT:        init_cnt   = i_cfg_data[1:0];
                    CFG_GLOBAL_HIST: glob_hist  = i_cfg_data[0];
                    CFG_GLOBAL_TBL:  glob_tbl   = i_cfg_data[0];
                    CFG_SHARE:       share      = i_cfg_data[1:0];
                    default: ;
                endcase
                if (i_cfg_index <= CFG_SHARE) clear_tables();
            end
            if (i_in_valid && i_in_ready) begin
                predict_branch(i_in, want);
                expected_q.push_back(want);
            end
        end
    end
endmodule
`default_nettype wire

>>> dv/tb_two_level_branch_predictor_btb.sv
// Testbench top: stimulus for the branch predictor with BTB, plus verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_two_level_branch_predictor_btb;
    import bpb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [4:0] cfg_data;
    logic       hold_off_go;
    int         fail_count;
    int         pending;
    int         idle_cycles;

    logic [31:0] slot_pc     [8];
    logic [31:0] slot_target [8];

    two_level_branch_predictor_btb u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bpb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_branch(input t_in_item it);
        int unsigned gap;
        logic        rdy;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        forever begin
            @(negedge i_clk);
            rdy = in_ready;
            @(posedge i_clk);
            if (rdy) break;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever begin
            @(negedge i_clk);
            rdy = cfg_ready;
            @(posedge i_clk);
            if (rdy) break;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic new_slots();
        for (int s = 0; s < 8; s++) begin
            slot_pc[s] = (32'($urandom_range(0, 3)) << 18) | (32'($urandom_range(0, 3)) << 12)
                         | (32'($urandom_range(0, 15)) << 2);
            slot_target[s] = $urandom;
        end
    endtask

    function automatic t_in_item make_branch(input logic upd, input logic [31:0] pc,
                                             input logic [31:0] tgt, input logic t,
                                             input logic [31:0] pa);
        t_in_item it;
        it.kind              = upd;
        it.pc                = pc;
        it.target_address    = tgt;
        it.taken             = t;
        it.predicted_address = pa;
        return it;
    endfunction

    function automatic t_in_item random_branch();
        t_in_item    it;
        int unsigned s, r;
        s = $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        if (r < 8) return make_branch(1'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
        if ($urandom_range(0, 9) == 0) slot_target[s] = $urandom;
        it = make_branch(1'($urandom_range(0, 1)), slot_pc[s], slot_target[s],
                         ($urandom_range(0, 9) < 7) ^ s[0], 32'h0);
        r = $urandom_range(0, 9);
        it.predicted_address = (r < 4) ? it.pc + 32'd4 : (r < 8) ? it.target_address : $urandom;
        return it;
    endfunction

    task automatic configure(input logic [4:0] v [7]);
        write_reg(CFG_LINES, v[0]);
        write_reg(CFG_HISTORY, v[1]);
        write_reg(CFG_TAG, v[2]);
        write_reg(CFG_INIT, v[3]);
        write_reg(CFG_GLOBAL_HIST, v[4]);
        write_reg(CFG_GLOBAL_TBL, v[5]);
        write_reg(CFG_SHARE, v[6]);
    endtask

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_go && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [4:0] cfg_sets [9][7];
        logic [4:0] one_set [7];
        cfg_sets = '{
            '{5'd5, 5'd8, 5'd30, 5'd3, 5'd0, 5'd0, 5'd0},
            '{5'd0, 5'd1, 5'd0, 5'd0, 5'd1, 5'd1, 5'd0},
            '{5'd3, 5'd4, 5'd10, 5'd2, 5'd1, 5'd1, 5'd1},
            '{5'd2, 5'd6, 5'd5, 5'd1, 5'd0, 5'd1, 5'd2},
            '{5'd4, 5'd8, 5'd30, 5'd0, 5'd1, 5'd0, 5'd3},
            '{5'd31, 5'd0, 5'd31, 5'd3, 5'd0, 5'd1, 5'd1},
            '{5'd5, 5'd15, 5'd20, 5'd2, 5'd1, 5'd1, 5'd2},
            '{5'd1, 5'd3, 5'd2, 5'd1, 5'd1, 5'd0, 5'd0},
            '{5'd2, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31}
        };
        i_rst_n     <= 1'b0;
        in_valid    <= 1'b0;
        in_item     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        hold_off_go <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_branch(make_branch(1'b0, 32'h0, 32'h0, 1'b0, 32'h0));
        send_branch(make_branch(1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
        send_branch(make_branch(1'b0, 32'h0, 32'h0, 1'b0, 32'h0));
        send_branch(make_branch(1'b1, 32'h0, 32'h1234_5678, 1'b1, 32'h0));
        send_branch(make_branch(1'b0, 32'h0, 32'h0, 1'b0, 32'h0));
        send_branch(make_branch(1'b1, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0));
        send_branch(make_branch(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0));
        send_branch(make_branch(1'b0, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0));
        send_branch(make_branch(1'b1, 32'hFFFF_FFFC, 32'hAAAA_5555, 1'b0, 32'h5555_AAAA));
        send_branch(make_branch(1'b1, 32'hFFFF_FFFC, 32'h8000_0000, 1'b1, 32'h8000_0000));
        send_branch(make_branch(1'b1, 32'hFFFF_FFFC, 32'h8000_0000, 1'b1, 32'h8000_0000));
        send_branch(make_branch(1'b0, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0));
        send_branch(make_branch(1'b1, 32'h0000_0004, 32'h0000_0010, 1'b0, 32'h0000_0008));
        send_branch(make_branch(1'b0, 32'h0000_0004, 32'h0, 1'b1, 32'h0));
        send_branch(make_branch(1'b1, 32'h7FFF_FFF8, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF));
        send_branch(make_branch(1'b0, 32'h7FFF_FFF8, 32'h0, 1'b0, 32'h0));
        drain();

        for (int p = 0; p < 11; p++) begin
            if (p < 9) begin
                one_set = cfg_sets[p];
            end else begin
                for (int k = 0; k < 7; k++) one_set[k] = 5'($urandom_range(0, 31));
            end
            configure(one_set);
            new_slots();
            for (int n = 0; n < 50; n++) begin
                if (p == 1 && n == 5) hold_off_go <= 1'b1;
                send_branch(random_branch());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
